### rtl/bitmap_allocator_find_first_zero_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap allocator
// Clocked implication checks sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ALLOCATOR_FIND_FIRST_ZERO_ASSERT_SVH
`define BITMAP_ALLOCATOR_FIND_FIRST_ZERO_ASSERT_SVH

// same-cycle implication
`define BAFZ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BAFZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bafz_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap allocator package
// Field types, request kinds and result status codes.
// ----------------------------------------------------------------------------
package bafz_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_SEL_W = 6;

  typedef logic [1:0]  kind_t;
  typedef logic [9:0]  index_t;
  typedef logic [1:0]  status_t;
  typedef logic [10:0] size_t;

  localparam kind_t KIND_SET   = 2'd0;
  localparam kind_t KIND_CLEAR = 2'd1;
  localparam kind_t KIND_TEST  = 2'd2;
  localparam kind_t KIND_FIND  = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_RANGE = 2'd1;
  localparam status_t STATUS_NONE  = 2'd2;

  localparam size_t SIZE_RESET = 11'd1024;

endpackage

### rtl/bafz_in_if.sv
// ----------------------------------------------------------------------------
// Bitmap allocator request channel
// Valid/ready channel carrying one request beat: kind and bit index.
// ----------------------------------------------------------------------------
interface bafz_in_if;
  import bafz_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  index_t index;

  modport source (output valid, output kind, output index, input ready);
  modport sink   (input valid, input kind, input index, output ready);
endinterface

### rtl/bafz_out_if.sv
// ----------------------------------------------------------------------------
// Bitmap allocator result channel
// Valid/ready channel carrying one result beat: status, tested bit, free index.
// ----------------------------------------------------------------------------
interface bafz_out_if;
  import bafz_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  logic    bit_value;
  index_t  free_index;

  modport source (output valid, output status, output bit_value, output free_index,
                  input ready);
  modport sink   (input valid, input status, input bit_value, input free_index,
                  output ready);
endinterface

### rtl/bafz_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module bafz_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bitmap_allocator_find_first_zero.sv
// Results: out-of-range answered from idle; set, clear and test go through the access state.
// Scan: one 64-bit word read from the bitmap RAM per cycle, up to the last configured word.
// Requests: one at a time; the next is accepted in the cycle after the result beat is taken.
// Reset: size returns to 1024 and a clearing pass writes zeros to all WORD_COUNT words,
// one word per cycle, before the first request is accepted.
// ----------------------------------------------------------------------------
// Bitmap allocator with find-first-zero
// Word-wide bitmap in RAM; set, clear, test one bit or scan for the lowest zero.
// ----------------------------------------------------------------------------
`include "bitmap_allocator_find_first_zero_assert.svh"

module bitmap_allocator_find_first_zero #(
  parameter int CAPACITY_BITS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  bafz_pkg::size_t     cfg_wdata,
  bafz_in_if.sink             in_ch,
  bafz_out_if.source          out_ch
);
  import bafz_pkg::*;

  localparam int WORD_COUNT = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int XW         = (WAW > 5) ? WAW : 5;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;
  localparam logic [1:0] ST_SCAN   = 2'd3;

  function automatic logic [BIT_SEL_W-1:0] lowest_one(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] low_mask;
    logic [BIT_SEL_W-1:0] pos;
    v   = x;
    pos = '0;
    for (int k = BIT_SEL_W - 1; k >= 0; k--) begin
      low_mask = (WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1);
      if ((v & low_mask) == '0) begin
        v      = v >> (1 << k);
        pos[k] = 1'b1;
      end
    end
    return pos;
  endfunction

  logic [1:0]           state_r, state_nxt;
  logic [WAW-1:0]       word_r, word_nxt;
  size_t                size_r;
  kind_t                kind_r;
  index_t               idx_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic                 out_bit_r, out_bit_nxt;
  index_t               out_free_r, out_free_nxt;

  logic                 ram_we;
  logic [WAW-1:0]       ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WAW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  size_t                used;
  size_t                used_m1;
  logic                 in_accept;
  logic                 in_range;
  logic                 last_scan;
  logic                 partial_word;
  logic [WORD_BITS-1:0] scan_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] bit_mask;

  bafz_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT),
    .AW    (WAW)
  ) u_bafz_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign used         = (32'(size_r) > CAPACITY_BITS) ? 11'(CAPACITY_BITS) : size_r;
  assign used_m1      = used - 11'd1;
  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_range     = {1'b0, in_ch.index} < used;
  assign last_scan    = XW'(word_r) == XW'(used_m1[10:BIT_SEL_W]);
  assign partial_word = XW'(word_r) == XW'(used[10:BIT_SEL_W]);
  assign scan_mask    = partial_word ? ~({WORD_BITS{1'b1}} << used[BIT_SEL_W-1:0])
                                     : {WORD_BITS{1'b1}};
  assign free_bits    = ~ram_rdata & scan_mask;
  assign bit_mask     = WORD_BITS'(1) << idx_r[BIT_SEL_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    word_nxt       = word_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_bit_nxt    = out_bit_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_waddr      = WAW'(idx_r >> BIT_SEL_W);
    ram_wdata      = '0;
    ram_raddr      = WAW'(in_ch.index >> BIT_SEL_W);
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = word_r;
        if (word_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
          word_nxt  = '0;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          out_status_nxt = STATUS_OK;
          out_bit_nxt    = 1'b0;
          out_free_nxt   = '0;
          if (in_ch.kind == KIND_FIND) begin
            if (used == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STATUS_NONE;
            end else begin
              ram_raddr = '0;
              word_nxt  = '0;
              state_nxt = ST_SCAN;
            end
          end else if (!in_range) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_RANGE;
          end else begin
            state_nxt = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        unique case (kind_r)
          KIND_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_mask;
          end
          KIND_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
          end
          KIND_TEST: begin
            out_bit_nxt = |(ram_rdata & bit_mask);
          end
          KIND_FIND: begin
          end
        endcase
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        ram_raddr = word_r + 1'b1;
        if (free_bits != '0) begin
          out_valid_nxt = 1'b1;
          out_free_nxt  = 10'({word_r, lowest_one(free_bits)});
          state_nxt     = ST_IDLE;
        end else if (last_scan) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_NONE;
          state_nxt      = ST_IDLE;
        end else begin
          word_nxt = word_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      word_r      <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_bit_r    <= out_bit_nxt;
    out_free_r   <= out_free_nxt;
    if (in_accept) begin
      kind_r <= in_ch.kind;
      idx_r  <= in_ch.index;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.bit_value  = out_bit_r;
  assign out_ch.free_index = out_free_r;

  `BAFZ_ASSERT_NEXT(a_accept_progress, in_accept,
    out_valid_r || state_r == ST_ACCESS || state_r == ST_SCAN,
    "accepted beat neither answered nor in progress")
  `BAFZ_ASSERT_NOW(a_write_state, ram_we,
    state_r == ST_ACCESS || state_r == ST_CLEAR,
    "bitmap write outside clear pass or access")
  `BAFZ_ASSERT_NOW(a_scan_bound, state_r == ST_SCAN,
    XW'(word_r) <= XW'(used_m1[10:BIT_SEL_W]) && used != '0,
    "scan word beyond configured size")
  `BAFZ_ASSERT_NOW(a_status_code, out_valid_r,
    out_status_r == STATUS_OK || out_status_r == STATUS_RANGE || out_status_r == STATUS_NONE,
    "undefined status on result beat")

endmodule
